// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
	else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition");
`endif

// ===== src/itchx_pkg.sv =====
// Package for the message field extractor: layout table, phases, status codes.
// No dependencies.
`default_nettype none
package itchx_pkg;
	localparam int unsigned SymbolBytes = 8;
	localparam logic [4:0] SkipField = 5'd31;

	typedef enum logic [1:0] {
		PH_LEN_HI = 2'd0,
		PH_LEN_LO = 2'd1,
		PH_TYPE   = 2'd2,
		PH_BODY   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNKNOWN   = 2'd1,
		ST_TRUNCATED = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  msg_code;
		logic [4:0]  field_index;
		logic [63:0] field_value;
		logic [3:0]  field_bytes;
		status_t     status;
		logic        last_of_message;
	} result_t;

	localparam logic [3:0] Sym = SymbolBytes[3:0];

	// Known message type code.
	function automatic logic type_known(input logic [7:0] c);
		case (c)
			"S", "R", "H", "Y", "L", "V", "W", "K", "J", "h", "A", "F",
			"E", "C", "X", "D", "U", "P", "Q", "B", "I", "N", "O": type_known = 1'b1;
			default: type_known = 1'b0;
		endcase
	endfunction

	// Field size in bytes; 0 past the end of the layout or for unknown types.
	function automatic logic [3:0] field_size(input logic [7:0] c, input logic [4:0] f);
		logic [3:0] s;
		s = 4'd0;
		if (f == 5'd0 || f == 5'd1) s = 4'd2;
		else if (f == 5'd2) s = 4'd6;
		if (!type_known(c)) s = 4'd0;
		else if (f > 5'd2) begin
			case (c)
				"S", "W": s = (f == 5'd3) ? 4'd1 : 4'd0;
				"R": begin
					case (f)
						5'd3: s = Sym;
						5'd4, 5'd5, 5'd7, 5'd8, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14,
						5'd16: s = 4'd1;
						5'd6, 5'd15: s = 4'd4;
						5'd9: s = 4'd2;
						default: s = 4'd0;
					endcase
				end
				"H": begin
					case (f)
						5'd3: s = Sym;
						5'd4, 5'd5: s = 4'd1;
						5'd6: s = 4'd4;
						default: s = 4'd0;
					endcase
				end
				"Y", "N": s = (f == 5'd3) ? Sym : (f == 5'd4) ? 4'd1 : 4'd0;
				"L": begin
					case (f)
						5'd3: s = 4'd4;
						5'd4: s = Sym;
						5'd5, 5'd6, 5'd7: s = 4'd1;
						default: s = 4'd0;
					endcase
				end
				"V": s = (f <= 5'd5) ? 4'd8 : 4'd0;
				"K": begin
					case (f)
						5'd3: s = Sym;
						5'd4, 5'd6: s = 4'd4;
						5'd5: s = 4'd1;
						default: s = 4'd0;
					endcase
				end
				"J": s = (f == 5'd3) ? Sym : (f <= 5'd7) ? 4'd4 : 4'd0;
				"h": s = (f == 5'd3) ? Sym : (f <= 5'd5) ? 4'd1 : 4'd0;
				"A", "F", "P": begin
					case (f)
						5'd3: s = 4'd8;
						5'd4: s = 4'd1;
						5'd5, 5'd7: s = 4'd4;
						5'd6: s = Sym;
						5'd8: s = (c == "F") ? 4'd4 : (c == "P") ? 4'd8 : 4'd0;
						default: s = 4'd0;
					endcase
				end
				"E", "C": begin
					case (f)
						5'd3, 5'd5: s = 4'd8;
						5'd4: s = 4'd4;
						5'd6: s = (c == "C") ? 4'd1 : 4'd0;
						5'd7: s = (c == "C") ? 4'd4 : 4'd0;
						default: s = 4'd0;
					endcase
				end
				"X": s = (f == 5'd3) ? 4'd8 : (f == 5'd4) ? 4'd4 : 4'd0;
				"D", "B": s = (f == 5'd3) ? 4'd8 : 4'd0;
				"U": s = (f <= 5'd4) ? 4'd8 : (f <= 5'd6) ? 4'd4 : 4'd0;
				"Q": begin
					case (f)
						5'd3, 5'd6: s = 4'd8;
						5'd4: s = Sym;
						5'd5: s = 4'd4;
						5'd7: s = 4'd1;
						default: s = 4'd0;
					endcase
				end
				"I": begin
					case (f)
						5'd3, 5'd4: s = 4'd8;
						5'd5, 5'd10, 5'd11: s = 4'd1;
						5'd6: s = Sym;
						5'd7, 5'd8, 5'd9: s = 4'd4;
						default: s = 4'd0;
					endcase
				end
				"O": begin
					case (f)
						5'd3: s = Sym;
						5'd4: s = 4'd1;
						5'd5, 5'd6, 5'd7, 5'd9, 5'd10: s = 4'd4;
						5'd8: s = 4'd8;
						default: s = 4'd0;
					endcase
				end
				default: s = 4'd0;
			endcase
		end
		field_size = s;
	endfunction
endpackage
`default_nettype wire

// ===== src/itchx_parser.sv =====
// Per-byte framing and field extraction state, one byte per cycle while byte_en is high.
// Depends on itchx_pkg.
`default_nettype none
module itchx_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_en,
	input  wire logic [7:0]         data_byte,
	output logic                    res_valid,
	output itchx_pkg::result_t      res
);
	itchx_pkg::phase_t phase_q;
	logic [15:0] remaining_q;
	logic [7:0]  type_q;
	logic [4:0]  field_q;
	logic [3:0]  count_q;
	logic [63:0] acc_q;

	itchx_pkg::phase_t phase_d;
	logic [15:0] remaining_d, rem_dec;
	logic [7:0]  type_d;
	logic [4:0]  field_d;
	logic [3:0]  count_d, size, cnt_inc;
	logic [63:0] acc_d, acc_sh;
	logic        final_field;

	assign rem_dec = remaining_q - 16'd1;
	assign size = itchx_pkg::field_size(type_q, field_q);
	assign acc_sh = {acc_q[55:0], data_byte};
	assign cnt_inc = count_q + 4'd1;
	assign final_field = (itchx_pkg::field_size(type_q, field_q + 5'd1) == 4'd0);

	always_comb begin
		phase_d = phase_q;
		remaining_d = remaining_q;
		type_d = type_q;
		field_d = field_q;
		count_d = count_q;
		acc_d = acc_q;
		res_valid = 1'b0;
		res = '{msg_code: type_q, field_index: field_q, field_value: acc_sh,
			field_bytes: cnt_inc, status: itchx_pkg::ST_OK, last_of_message: 1'b0};
		case (phase_q)
			itchx_pkg::PH_LEN_HI: begin
				remaining_d = {data_byte, 8'd0};
				phase_d = itchx_pkg::PH_LEN_LO;
			end
			itchx_pkg::PH_LEN_LO: begin
				remaining_d = remaining_q | {8'd0, data_byte};
				phase_d = (remaining_d != 16'd0) ? itchx_pkg::PH_TYPE : itchx_pkg::PH_LEN_HI;
			end
			itchx_pkg::PH_TYPE: begin
				type_d = data_byte;
				remaining_d = rem_dec;
				field_d = 5'd0;
				count_d = 4'd0;
				acc_d = '0;
				res.msg_code = data_byte;
				res.field_index = 5'd0;
				res.field_value = '0;
				res.field_bytes = 4'd0;
				res.last_of_message = 1'b1;
				if (!itchx_pkg::type_known(data_byte)) begin
					field_d = itchx_pkg::SkipField;
					phase_d = (rem_dec != 16'd0) ? itchx_pkg::PH_BODY : itchx_pkg::PH_LEN_HI;
					res_valid = 1'b1;
					res.status = itchx_pkg::ST_UNKNOWN;
				end else if (rem_dec == 16'd0) begin
					phase_d = itchx_pkg::PH_LEN_HI;
					res_valid = 1'b1;
					res.status = itchx_pkg::ST_TRUNCATED;
				end else begin
					phase_d = itchx_pkg::PH_BODY;
				end
			end
			default: begin
				remaining_d = rem_dec;
				if (size == 4'd0) begin
					if (rem_dec == 16'd0) phase_d = itchx_pkg::PH_LEN_HI;
				end else if (cnt_inc >= size) begin
					acc_d = '0;
					count_d = 4'd0;
					res_valid = 1'b1;
					if (final_field) begin
						field_d = itchx_pkg::SkipField;
						phase_d = (rem_dec != 16'd0) ? itchx_pkg::PH_BODY : itchx_pkg::PH_LEN_HI;
						res.last_of_message = 1'b1;
					end else if (rem_dec == 16'd0) begin
						phase_d = itchx_pkg::PH_LEN_HI;
						res.status = itchx_pkg::ST_TRUNCATED;
						res.last_of_message = 1'b1;
					end else begin
						field_d = field_q + 5'd1;
					end
				end else begin
					acc_d = acc_sh;
					count_d = cnt_inc;
					if (rem_dec == 16'd0) begin
						phase_d = itchx_pkg::PH_LEN_HI;
						res_valid = 1'b1;
						res.status = itchx_pkg::ST_TRUNCATED;
						res.last_of_message = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= itchx_pkg::PH_LEN_HI;
			remaining_q <= '0;
			type_q <= '0;
			field_q <= '0;
			count_q <= '0;
			acc_q <= '0;
		end else if (byte_en) begin
			phase_q <= phase_d;
			remaining_q <= remaining_d;
			type_q <= type_d;
			field_q <= field_d;
			count_q <= count_d;
			acc_q <= acc_d;
		end
	end
endmodule
`default_nettype wire

// ===== src/itchx_out_buf.sv =====
// Two-entry skid buffer on the result side.
// Depends on itchx_pkg.
`default_nettype none
module itchx_out_buf (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire itchx_pkg::result_t in_res,
	output logic                    in_ready,
	output logic                    out_valid,
	output itchx_pkg::result_t      out_res,
	input  wire logic               out_ready
);
	logic main_v_q, skid_v_q;
	itchx_pkg::result_t main_q, skid_q;

	assign in_ready = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!main_v_q || out_ready) begin
				main_v_q <= skid_v_q || in_valid;
				skid_v_q <= 1'b0;
			end else if (in_valid && !skid_v_q) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || out_ready) begin
			main_q <= skid_v_q ? skid_q : in_res;
		end else if (in_valid && !skid_v_q) begin
			skid_q <= in_res;
		end
	end
endmodule
`default_nettype wire

// ===== src/itch_message_field_extractor.sv =====
// Top level of the message field extractor: byte stream in, field stream out.
// Depends on itchx_pkg, itchx_parser, itchx_out_buf and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Takes one byte of a length-prefixed message stream per transaction and
// gives at most one field transaction per byte. Every byte is handled by the
// layout table lookup and an 8-bit shift into the field accumulator, so a
// byte may be accepted every cycle; the input stalls only while the
// two-entry output skid buffer is full. The result of the byte that completes
// a field is registered in the output buffer before its output transaction.
// m_tdata: msg_code[7:0], field_index[12:8], field_value[76:13],
//          field_bytes[80:77], zero fill to 88 bits.
// m_tuser: status[1:0]. m_tlast: last_of_message.
module itch_message_field_extractor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // msg_code, field_index, field_value, field_bytes
	output logic [1:0]       m_tuser,   // status
	output logic             m_tlast
);
	logic byte_en, res_valid;
	itchx_pkg::result_t res, out_res;

	// Byte handled only when the buffer can take any result it makes.
	assign byte_en = s_tvalid && s_tready;

	itchx_parser u_parser (
		.clk(clk), .arst_n(arst_n), .byte_en(byte_en), .data_byte(s_tdata),
		.res_valid(res_valid), .res(res)
	);

	itchx_out_buf u_buf (
		.clk(clk), .arst_n(arst_n), .in_valid(res_valid && byte_en), .in_res(res),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_res(out_res), .out_ready(m_tready)
	);

	assign m_tdata = {7'd0, out_res.field_bytes, out_res.field_value,
		out_res.field_index, out_res.msg_code};
	assign m_tuser = out_res.status;
	assign m_tlast = out_res.last_of_message;

	`ASSERT_NEVER(a_unknown_is_last, clk, arst_n, m_tvalid && m_tuser == itchx_pkg::ST_UNKNOWN && !m_tlast)
	`ASSERT_NEVER(a_bytes_range, clk, arst_n, m_tvalid && m_tdata[80:77] > 4'd8)
	`ASSERT_IMPL(a_stall_hold, clk, arst_n, (m_tvalid && !m_tready) |=> m_tvalid)
	`ASSERT_NEVER(a_status_code, clk, arst_n, m_tvalid && m_tuser > itchx_pkg::ST_TRUNCATED)
endmodule
`default_nettype wire
